[src/bsmd_pkg.sv]
// Shared constants, codes and interface structs for the batched sorted set.
// No dependencies; imported by the top level and bsmd_merge.
package bsmd_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int BATCH_W  = 11;
   localparam int INDEX_W  = 10;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [PADDR_W-3:0] REG_BATCH_SIZE = 1'd0;
   localparam logic [BATCH_W-1:0] BATCH_RESET    = 11'd341;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_ctl_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] prefix;
      logic             bank;
   } merge_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] total;
      logic             bank;
   } merge_rsp_type;

endpackage

[src/batched_sort_merge_dedup_set.sv]
// Top level of the batched sorted set: handshakes, config register, op control.
// Depends on bsmd_pkg, bsmd_ram (two banks) and bsmd_merge.
//
//   channel  ports                                   direction
//   req      req_valid req_stall req_op/key/index     in
//   rsp      rsp_valid rsp_stall rsp_status/value/count  out
//   csr      psel penable pwrite paddr pwdata prdata  in/out (APB)
//
// An insert that ends no batch, flush of a sorted store and op three go straight to
// the response state, a read via a read-data state. A merge adds sort passes over the
// tail, a prefix merge and dedupe; the single RAM write port per bank sets their pace.
// Reset is synchronous; store contents are not cleared, only the counts.
// A word is taken while an earlier result still waits on rsp_stall.
module batched_sort_merge_dedup_set
   import bsmd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [KEY_W-1:0]    rsp_read_value,
   output logic [CNT_W-1:0]    rsp_entry_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   typedef enum logic [1:0] {T_IDLE, T_RDATA, T_MERGE, T_DONE} state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in, sorted_ff, sorted_in, pending_ff, pending_in;
   logic                bank_ff, bank_in;
   logic [BATCH_W-1:0]  batch_ff, batch_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [KEY_W-1:0]    res_value_ff, res_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic          accept, csr_wr, csr_hit;
   mem_ctl_type   top_ctl, m_ctl0, m_ctl1, ctl0, ctl1;
   merge_req_type mreq;
   merge_rsp_type mrsp;
   logic [KEY_W-1:0] q0_a, q0_b, q1_a, q1_b;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != T_IDLE);
   assign csr_hit   = (paddr[PADDR_W-1:2] == REG_BATCH_SIZE);
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? PDATA_W'(batch_ff) : '0;
   assign batch_in  = (csr_wr && csr_hit) ? pwdata[BATCH_W-1:0] : batch_ff;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      sorted_in     = sorted_ff;
      pending_in    = pending_ff;
      bank_in       = bank_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      mreq.start    = 1'b0;
      mreq.prefix   = sorted_ff;
      mreq.bank     = bank_ff;
      top_ctl.we      = 1'b0;
      top_ctl.waddr   = total_ff[ADDR_W-1:0];
      top_ctl.wdata   = req_key;
      top_ctl.raddr_a = ADDR_W'(req_index);
      top_ctl.raddr_b = '0;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               res_status_in = ST_OK;
               res_value_in  = '0;
               state_in      = T_DONE;
               case (req_op)
                  OP_INSERT: begin
                     if (total_ff >= CNT_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        top_ctl.we = 1'b1;
                        total_in   = total_ff + CNT_W'(1);
                        pending_in = pending_ff + CNT_W'(1);
                        if (pending_in == CNT_W'(batch_ff)) begin
                           pending_in = '0;
                           mreq.start = 1'b1;
                           state_in   = T_MERGE;
                        end
                     end
                  end
                  OP_FLUSH: begin
                     pending_in = '0;
                     if ((sorted_ff != total_ff) && (total_ff != '0)) begin
                        mreq.start = 1'b1;
                        state_in   = T_MERGE;
                     end else begin
                        sorted_in = total_ff;
                     end
                  end
                  OP_READ: begin
                     if (CNT_W'(req_index) < total_ff) begin
                        state_in = T_RDATA;
                     end else begin
                        res_status_in = ST_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_RDATA: begin
            res_value_in = bank_ff ? q1_a : q0_a;
            state_in     = T_DONE;
         end
         T_MERGE: begin
            if (mrsp.done) begin
               total_in  = mrsp.total;
               sorted_in = mrsp.total;
               bank_in   = mrsp.bank;
               state_in  = T_DONE;
            end
         end
         T_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = total_ff;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      mreq.total = total_in;
   end

   // bank ports: merge engine while merging, else the op path on the live bank
   always_comb begin
      if (state_ff == T_MERGE) begin
         ctl0 = m_ctl0;
         ctl1 = m_ctl1;
      end else begin
         ctl0    = top_ctl;
         ctl1    = top_ctl;
         ctl0.we = top_ctl.we && !bank_ff;
         ctl1.we = top_ctl.we && bank_ff;
      end
   end

   bsmd_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_bank0 (
      .clock   (clock),
      .we      (ctl0.we),
      .waddr   (ctl0.waddr),
      .wdata   (ctl0.wdata),
      .raddr_a (ctl0.raddr_a),
      .raddr_b (ctl0.raddr_b),
      .rdata_a (q0_a),
      .rdata_b (q0_b)
   );

   bsmd_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_bank1 (
      .clock   (clock),
      .we      (ctl1.we),
      .waddr   (ctl1.waddr),
      .wdata   (ctl1.wdata),
      .raddr_a (ctl1.raddr_a),
      .raddr_b (ctl1.raddr_b),
      .rdata_a (q1_a),
      .rdata_b (q1_b)
   );

   bsmd_merge u_merge (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp),
      .q0_a  (q0_a),
      .q0_b  (q0_b),
      .q1_a  (q1_a),
      .q1_b  (q1_b),
      .ctl0  (m_ctl0),
      .ctl1  (m_ctl1)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         total_ff     <= '0;
         sorted_ff    <= '0;
         pending_ff   <= '0;
         bank_ff      <= 1'b0;
         batch_ff     <= BATCH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         sorted_ff    <= sorted_in;
         pending_ff   <= pending_in;
         bank_ff      <= bank_in;
         batch_ff     <= batch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

[src/bsmd_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module bsmd_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

[src/bsmd_merge.sv]
// Sort / merge / dedupe sequencer working over two ping-pong RAM banks.
// Depends on bsmd_pkg; drives the ports of both bsmd_ram banks while busy.
module bsmd_merge
   import bsmd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  merge_req_type req,
   output merge_rsp_type rsp,
   input  logic [KEY_W-1:0] q0_a,
   input  logic [KEY_W-1:0] q0_b,
   input  logic [KEY_W-1:0] q1_a,
   input  logic [KEY_W-1:0] q1_b,
   output mem_ctl_type   ctl0,
   output mem_ctl_type   ctl1
);

   typedef enum logic [2:0] {
      S_IDLE, S_FINAL, S_RUN_INIT, S_RUN, S_PASS_END, S_DD_INIT, S_DD_FIRST, S_DD_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] n_ff, n_in, p_ff, p_in, w_ff, w_in, lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in, hi_ff, hi_in, a_ff, a_in, b_ff, b_in, o_ff, o_in;
   logic sa_ff, sa_in, sb_ff, sb_in, d_ff, d_in, cur_ff, cur_in, orig_ff, orig_in;
   logic fin_ff, fin_in;
   logic [KEY_W-1:0] last_ff, last_in;

   logic [KEY_W-1:0] qa, qb, wr_data;
   logic             av, bv, take_a, take_b, wr_en;
   logic [CNT_W-1:0] tail_len, wr_addr;
   logic [SUM_W-1:0] w2, lo_w, lo_2w;

   assign qa       = sa_ff ? q1_a : q0_a;
   assign qb       = sb_ff ? q1_b : q0_b;
   assign av       = a_ff < mid_ff;
   assign bv       = b_ff < hi_ff;
   assign take_b   = bv && (!av || (qb < qa));
   assign take_a   = av && !take_b;
   assign tail_len = n_ff - p_ff;
   assign w2       = {w_ff, 1'b0};
   assign lo_w     = SUM_W'(lo_ff) + SUM_W'(w_ff);
   assign lo_2w    = SUM_W'(lo_ff) + w2;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      n_in = n_ff;  p_in = p_ff;  w_in = w_ff;  lo_in = lo_ff;
      mid_in = mid_ff;  hi_in = hi_ff;  a_in = a_ff;  b_in = b_ff;  o_in = o_ff;
      sa_in = sa_ff;  sb_in = sb_ff;  d_in = d_ff;  cur_in = cur_ff;  orig_in = orig_ff;
      fin_in  = fin_ff;
      last_in = last_ff;
      wr_en   = 1'b0;
      wr_addr = o_ff;
      wr_data = qa;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               n_in    = req.total;
               p_in    = req.prefix;
               orig_in = req.bank;
               cur_in  = req.bank;
               w_in    = CNT_W'(1);
               fin_in  = 1'b0;
               lo_in   = req.prefix;
               sa_in   = req.bank;
               sb_in   = req.bank;
               d_in    = ~req.bank;
               if ((req.total - req.prefix) > CNT_W'(1)) begin
                  state_in = S_RUN_INIT;
               end else begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            // merge any sorted prefix with the sorted tail, else go to dedupe; avoid writing the prefix bank
            if (p_ff != '0) begin
               fin_in   = 1'b1;
               lo_in    = '0;
               sa_in    = orig_ff;
               sb_in    = cur_ff;
               d_in     = (orig_ff == cur_ff) ? ~cur_ff : cur_ff;
               state_in = S_RUN_INIT;
            end else begin
               state_in = S_DD_INIT;
            end
         end
         S_RUN_INIT: begin
            if (fin_ff) begin
               mid_in = p_ff;
               hi_in  = n_ff;
            end else begin
               mid_in = (lo_w < SUM_W'(n_ff)) ? lo_w[CNT_W-1:0] : n_ff;
               hi_in  = (lo_2w < SUM_W'(n_ff)) ? lo_2w[CNT_W-1:0] : n_ff;
            end
            a_in     = lo_ff;
            b_in     = mid_in;
            o_in     = lo_ff;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (av || bv) begin
               wr_en   = 1'b1;
               wr_data = take_b ? qb : qa;
               o_in    = o_ff + CNT_W'(1);
               a_in    = a_ff + CNT_W'(take_a);
               b_in    = b_ff + CNT_W'(take_b);
            end else begin
               lo_in = hi_ff;
               if (fin_ff || (hi_ff == n_ff)) begin
                  state_in = S_PASS_END;
               end else begin
                  state_in = S_RUN_INIT;
               end
            end
         end
         S_PASS_END: begin
            cur_in = d_ff;
            if (fin_ff) begin
               state_in = S_DD_INIT;
            end else if (w2 < SUM_W'(tail_len)) begin
               w_in     = w2[CNT_W-1:0];
               lo_in    = p_ff;
               sa_in    = d_ff;
               sb_in    = d_ff;
               d_in     = ~d_ff;
               state_in = S_RUN_INIT;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DD_INIT: begin
            sa_in    = cur_ff;
            d_in     = cur_ff;
            a_in     = '0;
            state_in = S_DD_FIRST;
         end
         S_DD_FIRST: begin
            last_in  = qa;
            a_in     = CNT_W'(1);
            o_in     = CNT_W'(1);
            state_in = S_DD_SCAN;
         end
         S_DD_SCAN: begin
            // in place: write index never passes the read index
            if (a_ff < n_ff) begin
               if (qa != last_ff) begin
                  wr_en   = 1'b1;
                  last_in = qa;
                  o_in    = o_ff + CNT_W'(1);
               end
               a_in = a_ff + CNT_W'(1);
            end else begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl0.we      = wr_en && !d_ff;
      ctl0.waddr   = wr_addr[ADDR_W-1:0];
      ctl0.wdata   = wr_data;
      ctl0.raddr_a = a_in[ADDR_W-1:0];
      ctl0.raddr_b = b_in[ADDR_W-1:0];
      ctl1         = ctl0;
      ctl1.we      = wr_en && d_ff;
      rsp.done     = done_ff;
      rsp.total    = o_ff;
      rsp.bank     = cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff <= n_in;  p_ff <= p_in;  w_ff <= w_in;  lo_ff <= lo_in;
      mid_ff <= mid_in;  hi_ff <= hi_in;  a_ff <= a_in;  b_ff <= b_in;  o_ff <= o_in;
      sa_ff <= sa_in;  sb_ff <= sb_in;  d_ff <= d_in;  cur_ff <= cur_in;
      orig_ff <= orig_in;
      fin_ff  <= fin_in;
      last_ff <= last_in;
   end

endmodule
